>>> hdl/lpcp_pkg.sv
package lpcp_pkg;

  // Field widths.
  localparam int COORD_W = 18;
  localparam int COEF_W  = 16;
  localparam int PIX_W   = 15;
  localparam int KEPT_W  = 17;
  localparam int CAM_W   = 20;  // camera X and Y after offset and negation
  localparam int DEPTH_W = 18;  // positive depth magnitude
  localparam int REG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_X_LOWER  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_X_UPPER  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_Y_LOWER  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_UPPER  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL_U  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_U = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL_V  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_V = 3'd7;

  // Register reset values.
  localparam logic signed [COORD_W-1:0] RST_X_LOWER = 18'sd870;
  localparam logic signed [COORD_W-1:0] RST_X_UPPER = 18'sd51200;
  localparam logic signed [COORD_W-1:0] RST_Y_LOWER = -18'sd25600;
  localparam logic signed [COORD_W-1:0] RST_Y_UPPER = 18'sd25600;
  localparam logic [COEF_W-1:0] RST_FOCAL_U  = 16'd19472;
  localparam logic [COEF_W-1:0] RST_CENTER_U = 16'd17398;
  localparam logic [COEF_W-1:0] RST_FOCAL_V  = 16'd19346;
  localparam logic [COEF_W-1:0] RST_CENTER_V = 16'd13353;

  // Default module parameters.
  localparam int DEF_OFFSET_X     = -819;
  localparam int DEF_OFFSET_Y     = 0;
  localparam int DEF_OFFSET_Z     = 410;
  localparam int DEF_IMAGE_WIDTH  = 2048;
  localparam int DEF_IMAGE_HEIGHT = 1536;
  localparam int DEF_MAX_POINTS   = 131072;

  // Control from the top level to the projection engine.
  typedef struct packed {
    logic start;
    logic ack;
  } eng_ctl_t;

  // Status from the projection engine.
  typedef struct packed {
    logic done;
    logic on_image;
  } eng_sts_t;

endpackage

>>> hdl/lpcp_engine.sv
module lpcp_engine
  import lpcp_pkg::*;
#(
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  eng_ctl_t                  ctl,
  output eng_sts_t                  sts,
  input  logic signed [CAM_W-1:0]   cam_x,
  input  logic signed [CAM_W-1:0]   cam_y,
  input  logic [DEPTH_W-1:0]        depth,
  input  logic [COEF_W-1:0]         focal_u,
  input  logic [COEF_W-1:0]         center_u,
  input  logic [COEF_W-1:0]         focal_v,
  input  logic [COEF_W-1:0]         center_v,
  output logic [PIX_W-1:0]          pixel_u,
  output logic [PIX_W-1:0]          pixel_v
);

  localparam int MUL_A_W = COEF_W + 1;
  localparam int PROD_W  = MUL_A_W + CAM_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int REM_W   = DEPTH_W + PIX_W;
  localparam int CNT_W   = $clog2(PIX_W);
  localparam logic [PIX_W:0]   U_LIMIT = (PIX_W + 1)'(IMAGE_WIDTH * 16);
  localparam logic [PIX_W:0]   V_LIMIT = (PIX_W + 1)'(IMAGE_HEIGHT * 16);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PIX_W - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MULA  = 3'd1;
  localparam logic [2:0] ST_MULB  = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_AXIS  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]               state;
  logic                     phase;     // 0 works on u, 1 on v
  logic                     on_image;
  logic [CNT_W-1:0]         cnt;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [REM_W-1:0]         rem;
  logic [REM_W-1:0]         dsh;
  logic [PIX_W-1:0]         quo;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [CAM_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod_next;
  logic [ACC_W-1:0]          acc_lim;
  logic                      acc_ok;
  logic [REM_W:0]            diff;
  logic [PIX_W:0]            axis_limit;
  logic                      axis_ok;

  // Shared multiplier: coefficient times camera coordinate or depth.
  always_comb begin
    if (state == ST_MULB) begin
      mul_a = signed'({1'b0, (phase ? center_v : center_u)});
      mul_b = signed'({{(CAM_W - DEPTH_W){1'b0}}, depth});
    end else begin
      mul_a = signed'({1'b0, (phase ? focal_v : focal_u)});
      mul_b = phase ? cam_y : cam_x;
    end
    prod_next = mul_a * mul_b;
  end

  // A positive numerator below depth shifted by the quotient width gives a
  // quotient that fits; anything else is off the image.
  assign acc_lim = {{(ACC_W - REM_W){1'b0}}, depth, {PIX_W{1'b0}}};
  assign acc_ok  = (acc != '0) && (unsigned'(acc) < acc_lim);

  // Restoring division step.
  assign diff = {1'b0, rem} - {1'b0, dsh};

  // Image bounds on the finished quotient.
  assign axis_limit = phase ? V_LIMIT : U_LIMIT;
  assign axis_ok    = (quo != '0) && ({1'b0, quo} < axis_limit);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= 1'b0;
      on_image <= 1'b0;
      cnt      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            phase <= 1'b0;
            state <= ST_MULA;
          end
        end
        ST_MULA:  state <= ST_MULB;
        ST_MULB:  state <= ST_ADD;
        ST_ADD:   state <= ST_CHECK;
        ST_CHECK: begin
          cnt <= '0;
          if (acc_ok) begin
            state <= ST_DIV;
          end else begin
            on_image <= 1'b0;
            state    <= ST_DONE;
          end
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            state <= ST_AXIS;
          end
        end
        ST_AXIS: begin
          if (!axis_ok) begin
            on_image <= 1'b0;
            state    <= ST_DONE;
          end else if (!phase) begin
            phase <= 1'b1;
            state <= ST_MULA;
          end else begin
            on_image <= 1'b1;
            state    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (ctl.ack) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= prod_next;
    case (state)
      ST_MULB: acc <= {prod[PROD_W-1], prod};
      ST_ADD:  acc <= acc + {prod[PROD_W-1], prod};
      ST_CHECK: begin
        rem <= acc[REM_W-1:0];
        dsh <= {1'b0, depth, {(PIX_W - 1){1'b0}}};
        quo <= '0;
      end
      ST_DIV: begin
        if (!diff[REM_W]) begin
          rem <= diff[REM_W-1:0];
        end
        dsh <= dsh >> 1;
        quo <= {quo[PIX_W-2:0], ~diff[REM_W]};
      end
      ST_AXIS: begin
        if (!phase) begin
          pixel_u <= quo;
        end else begin
          pixel_v <= quo;
        end
      end
      default: ;
    endcase
  end

  assign sts.done     = (state == ST_DONE);
  assign sts.on_image = on_image;

endmodule

>>> hdl/lidar_point_camera_projection_top.sv
// Channel   Direction  Handshake             Beat contents
// cfg       in         cfg_we                cfg_index, cfg_data
// in        in         in_valid / in_ready   point_x, point_y, point_z, end_of_cloud
// out       out        out_valid / out_ready kept, pixel_u, pixel_v, point_index, cloud_done
//
// One point is worked on at a time. A point outside the box or with depth of zero
// or less bypasses the engine; a projected point goes through the shared multiplier
// (focal and centre products per axis) and the restoring divider (15 steps per axis).
// A result waiting in the output register does not hold off the next input beat;
// a full output register stalls the finish of the following point.
// Reset is synchronous and clears the registers to their reset values and the count.
module lidar_point_camera_projection_top
  import lpcp_pkg::*;
#(
  parameter int OFFSET_X     = DEF_OFFSET_X,
  parameter int OFFSET_Y     = DEF_OFFSET_Y,
  parameter int OFFSET_Z     = DEF_OFFSET_Z,
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
  parameter int MAX_POINTS   = DEF_MAX_POINTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [REG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  input  logic                      end_of_cloud,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      kept,
  output logic [PIX_W-1:0]          pixel_u,
  output logic [PIX_W-1:0]          pixel_v,
  output logic [KEPT_W-1:0]         point_index,
  output logic                      cloud_done
);

  localparam logic signed [COORD_W:0] OFF_X = (COORD_W + 1)'(OFFSET_X);
  localparam logic signed [CAM_W-1:0] OFF_Y = CAM_W'(OFFSET_Y);
  localparam logic signed [CAM_W-1:0] OFF_Z = CAM_W'(OFFSET_Z);
  localparam logic [KEPT_W-1:0]       CNT_LIMIT = KEPT_W'(MAX_POINTS - 1);

  // Configuration registers.
  logic signed [COORD_W-1:0] x_lower_limit;
  logic signed [COORD_W-1:0] x_upper_limit;
  logic signed [COORD_W-1:0] y_lower_limit;
  logic signed [COORD_W-1:0] y_upper_limit;
  logic [COEF_W-1:0]         focal_u;
  logic [COEF_W-1:0]         center_u;
  logic [COEF_W-1:0]         focal_v;
  logic [COEF_W-1:0]         center_v;

  // Control state.
  logic              busy;
  logic              use_eng;
  logic              start;
  logic [KEPT_W-1:0] kept_count;

  // Held point.
  logic signed [CAM_W-1:0] cam_x;
  logic signed [CAM_W-1:0] cam_y;
  logic [DEPTH_W-1:0]      depth;
  logic                    eoc;

  logic                    accept;
  logic                    finish;
  logic                    keep_now;
  logic                    box_ok;
  logic                    depth_pos;
  logic signed [COORD_W:0] depth_full;
  logic signed [CAM_W-1:0] cam_x_next;
  logic signed [CAM_W-1:0] cam_y_next;
  logic [PIX_W-1:0]        eng_u;
  logic [PIX_W-1:0]        eng_v;
  eng_ctl_t                ctl;
  eng_sts_t                sts;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_lower_limit <= RST_X_LOWER;
      x_upper_limit <= RST_X_UPPER;
      y_lower_limit <= RST_Y_LOWER;
      y_upper_limit <= RST_Y_UPPER;
      focal_u       <= RST_FOCAL_U;
      center_u      <= RST_CENTER_U;
      focal_v       <= RST_FOCAL_V;
      center_v      <= RST_CENTER_V;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_LOWER:  x_lower_limit <= signed'(cfg_data);
        REG_X_UPPER:  x_upper_limit <= signed'(cfg_data);
        REG_Y_LOWER:  y_lower_limit <= signed'(cfg_data);
        REG_Y_UPPER:  y_upper_limit <= signed'(cfg_data);
        REG_FOCAL_U:  focal_u       <= cfg_data[COEF_W-1:0];
        REG_CENTER_U: center_u      <= cfg_data[COEF_W-1:0];
        REG_FOCAL_V:  focal_v       <= cfg_data[COEF_W-1:0];
        REG_CENTER_V: center_v      <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Box test and lidar-to-camera axes.
  assign box_ok = (point_x >= x_lower_limit) && (point_x <= x_upper_limit) &&
                  (point_y >= y_lower_limit) && (point_y <= y_upper_limit);
  assign depth_full = {point_x[COORD_W-1], point_x} + OFF_X;
  assign depth_pos  = !depth_full[COORD_W] && (depth_full != '0);
  assign cam_x_next = CAM_W'(0) -
                      ({{(CAM_W - COORD_W){point_y[COORD_W-1]}}, point_y} + OFF_Y);
  assign cam_y_next = CAM_W'(0) -
                      ({{(CAM_W - COORD_W){point_z[COORD_W-1]}}, point_z} + OFF_Z);

  // Handshake.
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign finish   = busy && (!use_eng || sts.done) && (!out_valid || out_ready);
  assign keep_now = use_eng && sts.on_image;
  assign ctl.start = start;
  assign ctl.ack   = finish && use_eng;

  // Control and kept-point counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      use_eng    <= 1'b0;
      start      <= 1'b0;
      out_valid  <= 1'b0;
      kept_count <= '0;
    end else begin
      start <= accept && box_ok && depth_pos;
      if (accept) begin
        busy    <= 1'b1;
        use_eng <= box_ok && depth_pos;
      end
      // A finished point loads the output register; a taken beat empties it.
      out_valid <= finish || (out_valid && !out_ready);
      if (finish) begin
        busy <= 1'b0;
        if (eoc) begin
          kept_count <= '0;
        end else if (keep_now && (kept_count < CNT_LIMIT)) begin
          kept_count <= kept_count + 1'b1;
        end
      end
    end
  end

  // Point and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cam_x <= cam_x_next;
      cam_y <= cam_y_next;
      depth <= depth_full[DEPTH_W-1:0];
      eoc   <= end_of_cloud;
    end
    if (finish) begin
      kept        <= keep_now;
      pixel_u     <= keep_now ? eng_u : '0;
      pixel_v     <= keep_now ? eng_v : '0;
      point_index <= keep_now ? kept_count : '0;
      cloud_done  <= eoc;
    end
  end

  lpcp_engine #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .cam_x    (cam_x),
    .cam_y    (cam_y),
    .depth    (depth),
    .focal_u  (focal_u),
    .center_u (center_u),
    .focal_v  (focal_v),
    .center_v (center_v),
    .pixel_u  (eng_u),
    .pixel_v  (eng_v)
  );

endmodule

>>> hdl/lpcp_checker.sv
module lpcp_checker
  import lpcp_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_we,
  input logic [REG_IDX_W-1:0]      cfg_index,
  input logic [COORD_W-1:0]        cfg_data,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic signed [COORD_W-1:0] point_x,
  input logic signed [COORD_W-1:0] point_y,
  input logic signed [COORD_W-1:0] point_z,
  input logic                      end_of_cloud,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      kept,
  input logic [PIX_W-1:0]          pixel_u,
  input logic [PIX_W-1:0]          pixel_v,
  input logic [KEPT_W-1:0]         point_index,
  input logic                      cloud_done
);

  // A waiting result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kept) && $stable(pixel_u) &&
      $stable(pixel_v) && $stable(point_index) && $stable(cloud_done))
    else $error("output beat changed while stalled");

  // Only one point is in flight: an accepted beat closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a point is in work");

  // A dropped point carries zero pixel and index.
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kept |-> pixel_u == '0 && pixel_v == '0 && point_index == '0)
    else $error("dropped point carries nonzero fields");

  // A kept point has nonzero pixel coordinates, off the image's zero border.
  a_kept_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && kept |-> pixel_u != '0 && pixel_v != '0)
    else $error("kept point on the image border");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind lidar_point_camera_projection_top lpcp_checker u_lpcp_checker (.*);

>>> tb/pixel_checker.sv
module pixel_checker
  import lpcp_pkg::*;
#(
  parameter int OFFSET_X     = DEF_OFFSET_X,
  parameter int OFFSET_Y     = DEF_OFFSET_Y,
  parameter int OFFSET_Z     = DEF_OFFSET_Z,
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
  parameter int MAX_POINTS   = DEF_MAX_POINTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [REG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  input  logic                      end_of_cloud,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      kept,
  input  logic [PIX_W-1:0]          pixel_u,
  input  logic [PIX_W-1:0]          pixel_v,
  input  logic [KEPT_W-1:0]         point_index,
  input  logic                      cloud_done,
  output int                        awaited,
  output int                        mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              kept;
    logic [PIX_W-1:0]  u;
    logic [PIX_W-1:0]  v;
    logic [KEPT_W-1:0] index;
    logic              done;
  } pixel_beat_t;

  // Local copy of the configuration registers.
  logic signed [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic [COEF_W-1:0]         f_u, c_u, f_v, c_v;

  int          kept_in_cloud;
  pixel_beat_t expected_pixels[$];

  initial mismatches = 0;
  initial awaited = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // Box test, offset, axis swap, pinhole projection and image bounds test of one point.
  function automatic pixel_beat_t predict_pixel(logic signed [COORD_W-1:0] px,
                                                logic signed [COORD_W-1:0] py,
                                                logic signed [COORD_W-1:0] pz,
                                                logic eoc);
    pixel_beat_t r;
    longint      cx, cy, cz, u, v;
    r = '0;
    r.done = eoc;
    if (px >= x_lo && px <= x_hi && py >= y_lo && py <= y_hi) begin
      cx = -(longint'(py) + OFFSET_Y);
      cy = -(longint'(pz) + OFFSET_Z);
      cz = longint'(px) + OFFSET_X;
      if (cz > 0) begin
        // Signed division truncates toward zero, as the block must.
        u = (longint'(f_u) * cx + longint'(c_u) * cz) / cz;
        v = (longint'(f_v) * cy + longint'(c_v) * cz) / cz;
        if (u > 0 && u < longint'(IMAGE_WIDTH) * 16 &&
            v > 0 && v < longint'(IMAGE_HEIGHT) * 16) begin
          r.kept  = 1'b1;
          r.u     = PIX_W'(u);
          r.v     = PIX_W'(v);
          r.index = KEPT_W'(kept_in_cloud);
        end
      end
    end
    return r;
  endfunction

  // Follow register writes, predict each input beat and check each output beat.
  always @(posedge clk) begin
    pixel_beat_t got, want;
    if (rst) begin
      x_lo = RST_X_LOWER;
      x_hi = RST_X_UPPER;
      y_lo = RST_Y_LOWER;
      y_hi = RST_Y_UPPER;
      f_u  = RST_FOCAL_U;
      c_u  = RST_CENTER_U;
      f_v  = RST_FOCAL_V;
      c_v  = RST_CENTER_V;
      kept_in_cloud = 0;
      expected_pixels.delete();
      awaited <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_X_LOWER:  x_lo = cfg_data;
          REG_X_UPPER:  x_hi = cfg_data;
          REG_Y_LOWER:  y_lo = cfg_data;
          REG_Y_UPPER:  y_hi = cfg_data;
          REG_FOCAL_U:  f_u  = cfg_data[COEF_W-1:0];
          REG_CENTER_U: c_u  = cfg_data[COEF_W-1:0];
          REG_FOCAL_V:  f_v  = cfg_data[COEF_W-1:0];
          REG_CENTER_V: c_v  = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end

      // Output first: a beat leaving now cannot belong to a point entering now.
      if (out_valid && out_ready) begin
        got.kept  = kept;
        got.u     = pixel_u;
        got.v     = pixel_v;
        got.index = point_index;
        got.done  = cloud_done;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: %p", got));
        end else begin
          want = expected_pixels.pop_front();
          if (got.kept !== want.kept)
            report_mismatch($sformatf("kept %0d, expected %0d", got.kept, want.kept));
          if (got.u !== want.u)
            report_mismatch($sformatf("pixel_u %0d, expected %0d", got.u, want.u));
          if (got.v !== want.v)
            report_mismatch($sformatf("pixel_v %0d, expected %0d", got.v, want.v));
          if (got.index !== want.index)
            report_mismatch($sformatf("point_index %0d, expected %0d",
                                      got.index, want.index));
          if (got.done !== want.done)
            report_mismatch($sformatf("cloud_done %0d, expected %0d",
                                      got.done, want.done));
        end
      end

      if (in_valid && in_ready) begin
        want = predict_pixel(point_x, point_y, point_z, end_of_cloud);
        expected_pixels.insert(expected_pixels.size(), want);
        // The count saturates one below the limit and clears after the last point.
        if (want.kept && kept_in_cloud < MAX_POINTS - 1)
          kept_in_cloud++;
        if (end_of_cloud)
          kept_in_cloud = 0;
      end

      awaited <= expected_pixels.size();
    end
  end

endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lpcp_pkg::*;

  // A smaller point limit runs the block off its default size.
  localparam int SAT_POINTS = 1024;

  typedef enum {
    SET_RESET,
    SET_EDGE,
    SET_INVERTED,
    SET_WIDE_MAX,
    SET_SHUT,
    SET_RANDOM
  } setting_kind_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [REG_IDX_W-1:0]      cfg_index;
  logic [COORD_W-1:0]        cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic                      end_of_cloud;
  logic                      out_valid;
  logic                      out_ready;
  logic                      kept;
  logic [PIX_W-1:0]          pixel_u;
  logic [PIX_W-1:0]          pixel_v;
  logic [KEPT_W-1:0]         point_index;
  logic                      cloud_done;
  int                        awaited;
  int                        mismatches;

  // Register values the stimulus last programmed.
  logic [COORD_W-1:0] reg_plan [8];

  // Sender burst state and receiver stall state.
  int       burst_left = 0;
  int       idle_cycles = 0;
  int       stall_mode = 0;
  int       mode_left = 0;
  int       pat_pos = 0;
  logic [7:0] stall_mask = 8'hff;

  lidar_point_camera_projection_top #(
    .MAX_POINTS(SAT_POINTS)
  ) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .end_of_cloud(end_of_cloud),
    .out_valid(out_valid), .out_ready(out_ready),
    .kept(kept), .pixel_u(pixel_u), .pixel_v(pixel_v),
    .point_index(point_index), .cloud_done(cloud_done)
  );

  pixel_checker #(
    .MAX_POINTS(SAT_POINTS)
  ) u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .end_of_cloud(end_of_cloud),
    .out_valid(out_valid), .out_ready(out_ready),
    .kept(kept), .pixel_u(pixel_u), .pixel_v(pixel_v),
    .point_index(point_index), .cloud_done(cloud_done),
    .awaited(awaited), .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: alternate between always ready, coin flips and a repeating mask.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(2);
      mode_left  = $urandom_range(200, 20);
      stall_mask = 8'($urandom) | 8'h01;
    end
    mode_left--;
    pat_pos++;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(1));
      default: out_ready <= stall_mask[pat_pos % 8];
    endcase
  end

  function automatic int any_coord();
    return int'($urandom_range(262143)) - 131072;
  endfunction

  function automatic int clamp18(int val);
    if (val < -131072) return -131072;
    if (val > 131071) return 131071;
    return val;
  endfunction

  // Pick a point inside the programmed box with positive depth, spread
  // around the optical axis so that most land on the image; any point if the X range is empty.
  function automatic void aim_point(output int x, output int y, output int z);
    int lo, hi, ylo, yhi, cz, s;
    lo  = $signed(reg_plan[REG_X_LOWER]);
    hi  = $signed(reg_plan[REG_X_UPPER]);
    ylo = $signed(reg_plan[REG_Y_LOWER]);
    yhi = $signed(reg_plan[REG_Y_UPPER]);
    if (lo < 1 - DEF_OFFSET_X) lo = 1 - DEF_OFFSET_X;
    if (lo > hi) begin
      x = any_coord();
      y = any_coord();
      z = any_coord();
      return;
    end
    case ($urandom_range(7))
      0:       x = lo;
      1:       x = hi;
      default: x = lo + int'($urandom_range(hi - lo));
    endcase
    cz = x + DEF_OFFSET_X;
    s  = cz / 2 + 1;
    y  = -DEF_OFFSET_Y + int'($urandom_range(2 * s)) - s;
    if (ylo <= yhi) begin
      if (y < ylo) y = ylo;
      if (y > yhi) y = yhi;
    end
    y = clamp18(y);
    s = cz / 3 + 1;
    z = clamp18(-DEF_OFFSET_Z + int'($urandom_range(2 * s)) - s);
  endfunction

  // One input beat; bursts of beats are separated by random idle gaps.
  task automatic send_point(int x, int y, int z, bit eoc);
    if (burst_left == 0) begin
      burst_left  = $urandom_range(12, 1);
      idle_cycles = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
    end
    burst_left--;
    @(negedge clk);
    repeat (idle_cycles) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    idle_cycles = 0;
    in_valid     <= 1'b1;
    point_x      <= COORD_W'(x);
    point_y      <= COORD_W'(y);
    point_z      <= COORD_W'(z);
    end_of_cloud <= eoc;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every expected result has come out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_regs();
    for (int i = REG_X_LOWER; i <= REG_CENTER_V; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_data  <= reg_plan[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic choose_settings(setting_kind_t kind);
    int xlo, yhalf;
    reg_plan[REG_X_LOWER]  = RST_X_LOWER;
    reg_plan[REG_X_UPPER]  = RST_X_UPPER;
    reg_plan[REG_Y_LOWER]  = RST_Y_LOWER;
    reg_plan[REG_Y_UPPER]  = RST_Y_UPPER;
    reg_plan[REG_FOCAL_U]  = COORD_W'(RST_FOCAL_U);
    reg_plan[REG_CENTER_U] = COORD_W'(RST_CENTER_U);
    reg_plan[REG_FOCAL_V]  = COORD_W'(RST_FOCAL_V);
    reg_plan[REG_CENTER_V] = COORD_W'(RST_CENTER_V);
    case (kind)
      SET_EDGE: begin
        // Unit depth with a focal of one pixel puts the image bounds in reach.
        reg_plan[REG_X_LOWER]  = COORD_W'(-131072);
        reg_plan[REG_X_UPPER]  = COORD_W'(131071);
        reg_plan[REG_Y_LOWER]  = COORD_W'(-131072);
        reg_plan[REG_Y_UPPER]  = COORD_W'(131071);
        reg_plan[REG_FOCAL_U]  = COORD_W'(16);
        reg_plan[REG_CENTER_U] = '0;
        reg_plan[REG_FOCAL_V]  = COORD_W'(16);
        reg_plan[REG_CENTER_V] = '0;
      end
      SET_INVERTED: begin
        reg_plan[REG_X_LOWER] = COORD_W'(1000);
        reg_plan[REG_X_UPPER] = COORD_W'(999);
      end
      SET_WIDE_MAX: begin
        reg_plan[REG_X_LOWER]  = COORD_W'(-131072);
        reg_plan[REG_X_UPPER]  = COORD_W'(131071);
        reg_plan[REG_Y_LOWER]  = COORD_W'(-131072);
        reg_plan[REG_Y_UPPER]  = COORD_W'(131071);
        reg_plan[REG_FOCAL_U]  = COORD_W'(65535);
        reg_plan[REG_CENTER_U] = COORD_W'(65535);
        reg_plan[REG_FOCAL_V]  = COORD_W'(65535);
        reg_plan[REG_CENTER_V] = COORD_W'(65535);
      end
      SET_SHUT: begin
        reg_plan[REG_X_LOWER]  = COORD_W'(131071);
        reg_plan[REG_X_UPPER]  = COORD_W'(-131072);
        reg_plan[REG_Y_LOWER]  = COORD_W'(131071);
        reg_plan[REG_Y_UPPER]  = COORD_W'(-131072);
        reg_plan[REG_FOCAL_U]  = '0;
        reg_plan[REG_CENTER_U] = '0;
        reg_plan[REG_FOCAL_V]  = '0;
        reg_plan[REG_CENTER_V] = '0;
      end
      SET_RANDOM: begin
        if ($urandom_range(4) == 0) begin
          reg_plan[REG_X_LOWER] = COORD_W'($urandom);
          reg_plan[REG_X_UPPER] = COORD_W'($urandom);
          reg_plan[REG_Y_LOWER] = COORD_W'($urandom);
          reg_plan[REG_Y_UPPER] = COORD_W'($urandom);
        end else begin
          xlo   = int'($urandom_range(22000)) - 2000;
          yhalf = $urandom_range(60000, 1000);
          reg_plan[REG_X_LOWER] = COORD_W'(xlo);
          reg_plan[REG_X_UPPER] = COORD_W'(clamp18(xlo + int'($urandom_range(100000, 1000))));
          reg_plan[REG_Y_LOWER] = COORD_W'(-yhalf + int'($urandom_range(2000)) - 1000);
          reg_plan[REG_Y_UPPER] = COORD_W'(yhalf + int'($urandom_range(2000)) - 1000);
        end
        // Coefficients: mostly plausible optics, sometimes any 18-bit word.
        for (int i = REG_FOCAL_U; i <= REG_CENTER_V; i++) begin
          if ($urandom_range(3) == 0)
            reg_plan[i] = COORD_W'($urandom);
          else if (i == REG_FOCAL_U || i == REG_FOCAL_V)
            reg_plan[i] = COORD_W'($urandom_range(40000, 8000));
          else
            reg_plan[i] = COORD_W'($urandom_range(30000, 4000));
        end
      end
      default: ;
    endcase
    program_regs();
  endtask

  // Stimulus and verdict.
  initial begin
    int x, y, z;
    setting_kind_t plan [8];
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    point_x      = '0;
    point_y      = '0;
    point_z      = '0;
    end_of_cloud = 1'b0;
    out_ready    = 1'b0;
    reg_plan[REG_X_LOWER]  = RST_X_LOWER;
    reg_plan[REG_X_UPPER]  = RST_X_UPPER;
    reg_plan[REG_Y_LOWER]  = RST_Y_LOWER;
    reg_plan[REG_Y_UPPER]  = RST_Y_UPPER;
    reg_plan[REG_FOCAL_U]  = COORD_W'(RST_FOCAL_U);
    reg_plan[REG_CENTER_U] = COORD_W'(RST_CENTER_U);
    reg_plan[REG_FOCAL_V]  = COORD_W'(RST_FOCAL_V);
    reg_plan[REG_CENTER_V] = COORD_W'(RST_CENTER_V);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset registers: inclusive box edges and extreme coordinates.
    send_point(870, 0, -410, 1'b0);
    send_point(869, 0, -410, 1'b0);
    send_point(51200, 0, -410, 1'b0);
    send_point(51201, 0, -410, 1'b0);
    send_point(51200, -25600, -410, 1'b0);
    send_point(51200, 25600, -410, 1'b0);
    send_point(51200, -25601, -410, 1'b0);
    send_point(51200, 25601, -410, 1'b1);
    send_point(-131072, -131072, -131072, 1'b0);
    send_point(131071, 131071, 131071, 1'b0);
    send_point(20000, 0, 131071, 1'b0);
    send_point(20000, 0, -131072, 1'b1);

    // Zero and negative depth, and the four image bounds.
    drain();
    choose_settings(SET_EDGE);
    send_point(819, 0, -411, 1'b0);
    send_point(818, -1, -411, 1'b0);
    send_point(-131072, -1, -411, 1'b0);
    send_point(820, 0, -411, 1'b0);
    send_point(820, -1, -411, 1'b0);
    send_point(820, -2047, -1945, 1'b0);
    send_point(820, -2048, -411, 1'b0);
    send_point(820, -1, -1946, 1'b0);
    send_point(820, -1, -410, 1'b1);

    // Lower limit above upper limit rejects everything.
    drain();
    choose_settings(SET_INVERTED);
    send_point(1000, 0, -410, 1'b0);
    send_point(999, 0, -410, 1'b1);

    // Random phases, each under its own register setting.
    plan = '{SET_RESET, SET_WIDE_MAX, SET_RANDOM, SET_SHUT,
             SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_RANDOM};
    foreach (plan[p]) begin
      drain();
      choose_settings(plan[p]);
      for (int n = 0; n < 35; n++) begin
        if ($urandom_range(3) != 0) begin
          aim_point(x, y, z);
        end else begin
          x = any_coord();
          y = any_coord();
          z = any_coord();
        end
        send_point(x, y, z, $urandom_range(9) == 0);
      end
    end

    // One long cloud of kept points, then a short one after the count clears.
    drain();
    choose_settings(SET_RESET);
    for (int n = 0; n < 90; n++)
      send_point(10000 + int'($urandom_range(1000)), int'($urandom_range(1000)) - 500,
                 -410 + int'($urandom_range(600)) - 300, n == 89);
    for (int n = 0; n < 4; n++)
      send_point(10000 + int'($urandom_range(1000)), 0, -410, n == 3);

    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
